>>> rtl/core/lci_pkg.sv
`default_nettype none

package lci_pkg;

    // Number of points reported for one query.
    typedef enum logic [1:0] {
        CNT_NONE = 2'd0,
        CNT_ONE  = 2'd1,
        CNT_TWO  = 2'd2
    } t_count;

endpackage

`default_nettype wire

>>> rtl/core/lci_sqrt_cell.sv
`default_nettype none

// One digit of a restoring square root: takes the top two radicand bits,
// decides one root bit and hands the partial state to the next cell.
module lci_sqrt_cell #(
    parameter int RW    = 24,
    parameter int TAG_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [2*RW-1:0]  i_rad,
    input  wire logic [RW+1:0]    i_rem,
    input  wire logic [RW-1:0]    i_root,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic                  o_valid,
    output logic [2*RW-1:0]       o_rad,
    output logic [RW+1:0]         o_rem,
    output logic [RW-1:0]         o_root,
    output logic [TAG_W-1:0]      o_tag
);

    logic             r_valid;
    logic [2*RW-1:0]  r_rad;
    logic [RW+1:0]    r_rem;
    logic [RW-1:0]    r_root;
    logic [TAG_W-1:0] r_tag;

    logic [2*RW-1:0]  n_rad;
    logic [RW+1:0]    n_rem;
    logic [RW-1:0]    n_root;
    logic [RW+1:0]    w_shift;
    logic [RW+1:0]    w_trial;
    logic             w_ge;

    // Bring down the next bit pair and try to subtract 4*root + 1.
    always_comb begin
        w_shift = {i_rem[RW-1:0], i_rad[2*RW-1 -: 2]};
        w_trial = {i_root, 2'b01};
        w_ge    = (w_shift >= w_trial);
        n_rem   = w_ge ? (w_shift - w_trial) : w_shift;
        n_root  = {i_root[RW-2:0], w_ge};
        n_rad   = {i_rad[2*RW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_tag  <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_tag   = r_tag;

endmodule

`default_nettype wire

>>> rtl/core/lci_div_cell.sv
`default_nettype none

// One quotient bit of two restoring dividers that share a divisor. The
// dividend shifts out at the top while quotient bits shift in at the bottom.
module lci_div_cell #(
    parameter int DW    = 32,
    parameter int NW    = 48,
    parameter int TAG_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [DW-1:0]    i_den,
    input  wire logic [DW-1:0]    i_rem_p,
    input  wire logic [NW-1:0]    i_nq_p,
    input  wire logic [DW-1:0]    i_rem_m,
    input  wire logic [NW-1:0]    i_nq_m,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic                  o_valid,
    output logic [DW-1:0]         o_den,
    output logic [DW-1:0]         o_rem_p,
    output logic [NW-1:0]         o_nq_p,
    output logic [DW-1:0]         o_rem_m,
    output logic [NW-1:0]         o_nq_m,
    output logic [TAG_W-1:0]      o_tag
);

    logic             r_valid;
    logic [DW-1:0]    r_den;
    logic [DW-1:0]    r_rem_p;
    logic [NW-1:0]    r_nq_p;
    logic [DW-1:0]    r_rem_m;
    logic [NW-1:0]    r_nq_m;
    logic [TAG_W-1:0] r_tag;

    logic [DW-1:0]    n_rem_p;
    logic [NW-1:0]    n_nq_p;
    logic [DW-1:0]    n_rem_m;
    logic [NW-1:0]    n_nq_m;

    // One restoring step: returns the new remainder and dividend/quotient word.
    function automatic logic [DW+NW-1:0] div_step(input logic [DW-1:0] rem,
                                                  input logic [NW-1:0] nq,
                                                  input logic [DW-1:0] den);
        logic [DW-1:0] sh;
        logic          ge;
        sh = {rem[DW-2:0], nq[NW-1]};
        ge = (sh >= den);
        return {(ge ? (sh - den) : sh), nq[NW-2:0], ge};
    endfunction

    always_comb begin
        {n_rem_p, n_nq_p} = div_step(i_rem_p, i_nq_p, i_den);
        {n_rem_m, n_nq_m} = div_step(i_rem_m, i_nq_m, i_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den   <= i_den;
            r_rem_p <= n_rem_p;
            r_nq_p  <= n_nq_p;
            r_rem_m <= n_rem_m;
            r_nq_m  <= n_nq_m;
            r_tag   <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_den   = r_den;
    assign o_rem_p = r_rem_p;
    assign o_nq_p  = r_nq_p;
    assign o_rem_m = r_rem_m;
    assign o_nq_m  = r_nq_m;
    assign o_tag   = r_tag;

endmodule

`default_nettype wire

>>> rtl/core/line_circle_intersection.sv
// Throughput: one word per cycle; the square root chain has one cell per root
// bit and the divider chain one cell per quotient bit, all stepping together.
// A held output word stalls the whole pipeline, input included.
// Reset (synchronous, active low) clears all valid bits; no clearing pass.
`default_nettype none

module line_circle_intersection
    import lci_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_s_axis_tvalid,
    output logic                                         o_s_axis_tready,
    // centre_x, centre_y, radius, slope, intercept (lowest first), zero pad
    input  wire logic [((5*WORD_BITS+6)/8)*8-1:0]        i_s_axis_tdata,
    output logic                                         o_m_axis_tvalid,
    input  wire logic                                    i_m_axis_tready,
    // first_x, first_y, second_x, second_y (lowest first), zero pad
    output logic [((4*WORD_BITS+7)/8)*8-1:0]             o_m_axis_tdata,
    // point_count, overflow (lowest first)
    output logic [2:0]                                   o_m_axis_tuser
);

    localparam int W     = WORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int XW    = W + 3;
    localparam int NW    = W + F;
    localparam int MW    = (2 * W > NW) ? 2 * W : NW;
    localparam int RW    = (W + F) / 2;
    localparam int OUT_W = ((4 * W + 7) / 8) * 8;

    localparam logic [W-1:0] POSMAG  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEGMAG  = {1'b1, {(W-1){1'b0}}};
    localparam logic         ONE_SAT = (F > W - 2);
    localparam logic [W-1:0] ONE     = ONE_SAT ? POSMAG : (W'(1) << F);

    typedef logic signed [XW-1:0] t_wide;

    typedef struct packed {
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [W-1:0] bq;
        logic [W-1:0] den;
        t_count       cnt;
        logic         f;
    } t_sq_tag;

    typedef struct packed {
        logic [W-1:0] a;
        logic [W-1:0] b;
        t_count       cnt;
        logic         f;
        logic         neg_p;
        logic         neg_m;
    } t_dv_tag;

    localparam int SQ_TAG = $bits(t_sq_tag);
    localparam int DV_TAG = $bits(t_dv_tag);

    // ---------------------------------------------------------------------
    // Saturating fixed-point helpers; clamp_w, from_mag and qmul return {saturated, value}.
    function automatic t_wide ext(input logic [W-1:0] v);
        return t_wide'($signed(v));
    endfunction

    function automatic logic [W:0] clamp_w(input t_wide v);
        t_wide hi;
        t_wide lo;
        hi = ext(POSMAG);
        lo = ext(NEGMAG);
        if (v > hi) begin
            return {1'b1, POSMAG};
        end else if (v < lo) begin
            return {1'b1, NEGMAG};
        end
        return {1'b0, v[W-1:0]};
    endfunction

    function automatic logic [W-1:0] abs_w(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [W:0] from_mag(input logic neg, input logic [MW-1:0] mag);
        logic [MW-1:0] lim;
        logic [W-1:0]  m;
        logic          sat;
        lim = neg ? MW'(NEGMAG) : MW'(POSMAG);
        sat = (mag > lim);
        m   = sat ? lim[W-1:0] : mag[W-1:0];
        return {sat, (neg ? (~m + 1'b1) : m)};
    endfunction

    function automatic logic [W:0] qmul(input logic [W-1:0] x, input logic [W-1:0] y);
        logic [2*W-1:0] p;
        p = abs_w(x) * abs_w(y);
        return from_mag(x[W-1] ^ y[W-1], MW'(p >> F));
    endfunction

    // ---------------------------------------------------------------------
    // Global advance: the pipeline moves unless the output word is held.
    logic w_en;
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // Stage 1: d = b - y0 and the squares that need only the inputs.
    logic         r_s1_valid;
    logic [W-1:0] r_s1_x0, r_s1_a, r_s1_b, r_s1_d, r_s1_aa, r_s1_xx, r_s1_rr;
    logic         r_s1_f;
    logic [W-1:0] w_x0, w_y0, w_a, w_b;
    logic [W-2:0] w_rr;
    logic [W:0]   n_s1_d, n_s1_aa, n_s1_xx, n_s1_rr;

    always_comb begin
        w_x0    = i_s_axis_tdata[W-1:0];
        w_y0    = i_s_axis_tdata[2*W-1:W];
        w_rr    = i_s_axis_tdata[3*W-2:2*W];
        w_a     = i_s_axis_tdata[4*W-2:3*W-1];
        w_b     = i_s_axis_tdata[5*W-2:4*W-1];
        n_s1_d  = clamp_w(ext(w_b) - ext(w_y0));
        n_s1_aa = qmul(w_a, w_a);
        n_s1_xx = qmul(w_x0, w_x0);
        n_s1_rr = qmul({1'b0, w_rr}, {1'b0, w_rr});
    end

    // Stage 2: a*d, d*d and A = 1 + a*a.
    logic         r_s2_valid;
    logic [W-1:0] r_s2_x0, r_s2_a, r_s2_b, r_s2_ad, r_s2_dd, r_s2_xx, r_s2_rr, r_s2_aq;
    logic         r_s2_f;
    logic [W:0]   n_s2_ad, n_s2_dd, n_s2_aq;

    always_comb begin
        n_s2_ad = qmul(r_s1_a, r_s1_d);
        n_s2_dd = qmul(r_s1_d, r_s1_d);
        n_s2_aq = clamp_w(ext(ONE) + ext(r_s1_aa));
    end

    // Stage 3: B, C and the divisor 2*A.
    logic         r_s3_valid;
    logic [W-1:0] r_s3_a, r_s3_b, r_s3_bq, r_s3_aq, r_s3_cq, r_s3_den;
    logic         r_s3_f;
    logic [W:0]   w_t, n_s3_bq, w_c1, n_s3_cq, n_s3_den;

    always_comb begin
        w_t      = clamp_w(ext(r_s2_x0) - ext(r_s2_ad));
        n_s3_bq  = clamp_w(ext(w_t[W-1:0]) <<< 1);
        w_c1     = clamp_w(ext(r_s2_xx) + ext(r_s2_dd));
        n_s3_cq  = clamp_w(ext(w_c1[W-1:0]) - ext(r_s2_rr));
        n_s3_den = clamp_w(ext(r_s2_aq) <<< 1);
    end

    // Stage 4: B*B and A*C.
    logic         r_s4_valid;
    logic [W-1:0] r_s4_a, r_s4_b, r_s4_bq, r_s4_den, r_s4_bb, r_s4_ac;
    logic         r_s4_f;
    logic [W:0]   n_s4_bb, n_s4_ac;

    always_comb begin
        n_s4_bb = qmul(r_s3_bq, r_s3_bq);
        n_s4_ac = qmul(r_s3_aq, r_s3_cq);
    end

    // Stage 5: discriminant.
    logic         r_s5_valid;
    logic [W-1:0] r_s5_a, r_s5_b, r_s5_bq, r_s5_den, r_s5_disc;
    logic         r_s5_f;
    logic [W:0]   w_ac4, n_s5_disc;

    always_comb begin
        w_ac4     = clamp_w(ext(r_s4_ac) <<< 2);
        n_s5_disc = clamp_w(ext(r_s4_bb) - ext(w_ac4[W-1:0]));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_x0   <= w_x0;
            r_s1_a    <= w_a;
            r_s1_b    <= w_b;
            r_s1_d    <= n_s1_d[W-1:0];
            r_s1_aa   <= n_s1_aa[W-1:0];
            r_s1_xx   <= n_s1_xx[W-1:0];
            r_s1_rr   <= n_s1_rr[W-1:0];
            r_s1_f    <= ONE_SAT | n_s1_d[W] | n_s1_aa[W] | n_s1_xx[W] | n_s1_rr[W];

            r_s2_x0   <= r_s1_x0;
            r_s2_a    <= r_s1_a;
            r_s2_b    <= r_s1_b;
            r_s2_ad   <= n_s2_ad[W-1:0];
            r_s2_dd   <= n_s2_dd[W-1:0];
            r_s2_xx   <= r_s1_xx;
            r_s2_rr   <= r_s1_rr;
            r_s2_aq   <= n_s2_aq[W-1:0];
            r_s2_f    <= r_s1_f | n_s2_ad[W] | n_s2_dd[W] | n_s2_aq[W];

            r_s3_a    <= r_s2_a;
            r_s3_b    <= r_s2_b;
            r_s3_bq   <= n_s3_bq[W-1:0];
            r_s3_aq   <= r_s2_aq;
            r_s3_cq   <= n_s3_cq[W-1:0];
            r_s3_den  <= n_s3_den[W-1:0];
            r_s3_f    <= r_s2_f | w_t[W] | n_s3_bq[W] | w_c1[W] | n_s3_cq[W] | n_s3_den[W];

            r_s4_a    <= r_s3_a;
            r_s4_b    <= r_s3_b;
            r_s4_bq   <= r_s3_bq;
            r_s4_den  <= r_s3_den;
            r_s4_bb   <= n_s4_bb[W-1:0];
            r_s4_ac   <= n_s4_ac[W-1:0];
            r_s4_f    <= r_s3_f | n_s4_bb[W] | n_s4_ac[W];

            r_s5_a    <= r_s4_a;
            r_s5_b    <= r_s4_b;
            r_s5_bq   <= r_s4_bq;
            r_s5_den  <= r_s4_den;
            r_s5_disc <= n_s5_disc[W-1:0];
            r_s5_f    <= r_s4_f | w_ac4[W] | n_s5_disc[W];
        end
    end

    // ---------------------------------------------------------------------
    // Square root chain, one root bit per cell. Only a positive
    // discriminant is fed in, so the root reads zero otherwise.
    logic              sq_valid [0:RW];
    logic [2*RW-1:0]   sq_rad   [0:RW-1];
    logic [RW+1:0]     sq_rem   [0:RW-1];
    logic [RW-1:0]     sq_root  [0:RW];
    logic [SQ_TAG-1:0] sq_tag   [0:RW];
    t_count            w_cnt;
    t_sq_tag           w_sq_in;

    always_comb begin
        if (r_s5_disc[W-1]) begin
            w_cnt = CNT_NONE;
        end else if (r_s5_disc == '0) begin
            w_cnt = CNT_ONE;
        end else begin
            w_cnt = CNT_TWO;
        end
        w_sq_in.a   = r_s5_a;
        w_sq_in.b   = r_s5_b;
        w_sq_in.bq  = r_s5_bq;
        w_sq_in.den = r_s5_den;
        w_sq_in.cnt = w_cnt;
        w_sq_in.f   = r_s5_f;
        sq_valid[0] = r_s5_valid;
        sq_rad[0]   = (w_cnt == CNT_TWO) ? (2*RW)'({r_s5_disc[W-2:0], {F{1'b0}}}) : '0;
        sq_rem[0]   = '0;
        sq_root[0]  = '0;
        sq_tag[0]   = w_sq_in;
    end

    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        if (g < RW - 1) begin : g_mid
            lci_sqrt_cell #(.RW(RW), .TAG_W(SQ_TAG)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (sq_valid[g]),
                .i_rad   (sq_rad[g]),
                .i_rem   (sq_rem[g]),
                .i_root  (sq_root[g]),
                .i_tag   (sq_tag[g]),
                .o_valid (sq_valid[g+1]),
                .o_rad   (sq_rad[g+1]),
                .o_rem   (sq_rem[g+1]),
                .o_root  (sq_root[g+1]),
                .o_tag   (sq_tag[g+1])
            );
        end else begin : g_last
            lci_sqrt_cell #(.RW(RW), .TAG_W(SQ_TAG)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (sq_valid[g]),
                .i_rad   (sq_rad[g]),
                .i_rem   (sq_rem[g]),
                .i_root  (sq_root[g]),
                .i_tag   (sq_tag[g]),
                .o_valid (sq_valid[g+1]),
                .o_rad   (),
                .o_rem   (),
                .o_root  (sq_root[g+1]),
                .o_tag   (sq_tag[g+1])
            );
        end
    end

    // Stage 6: numerators B + s and B - s, split into sign and magnitude.
    logic         r_s6_valid;
    logic [W-1:0] r_s6_den;
    logic [NW-1:0] r_s6_nq_p, r_s6_nq_m;
    t_dv_tag      r_s6_tag;
    t_sq_tag      w_sq_out;
    logic         w_rsat;
    logic [W-1:0] w_s;
    logic [W:0]   w_np, w_nm;
    t_dv_tag      n_s6_tag;

    always_comb begin
        w_sq_out       = t_sq_tag'(sq_tag[RW]);
        w_rsat         = ((RW+W)'(sq_root[RW]) > (RW+W)'(POSMAG));
        w_s            = w_rsat ? POSMAG : W'(sq_root[RW]);
        w_np           = clamp_w(ext(w_sq_out.bq) + ext(w_s));
        w_nm           = clamp_w(ext(w_sq_out.bq) - ext(w_s));
        n_s6_tag.a     = w_sq_out.a;
        n_s6_tag.b     = w_sq_out.b;
        n_s6_tag.cnt   = w_sq_out.cnt;
        n_s6_tag.f     = w_sq_out.f | w_rsat | w_np[W] | w_nm[W];
        n_s6_tag.neg_p = w_np[W-1];
        n_s6_tag.neg_m = w_nm[W-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_den  <= w_sq_out.den;
            r_s6_nq_p <= {abs_w(w_np[W-1:0]), {F{1'b0}}};
            r_s6_nq_m <= {abs_w(w_nm[W-1:0]), {F{1'b0}}};
            r_s6_tag  <= n_s6_tag;
        end
    end

    // ---------------------------------------------------------------------
    // Divider chain, one quotient bit of both numerators per cell.
    logic              dv_valid [0:NW];
    logic [W-1:0]      dv_den   [0:NW];
    logic [W-1:0]      dv_rem_p [0:NW-1];
    logic [NW-1:0]     dv_nq_p  [0:NW];
    logic [W-1:0]      dv_rem_m [0:NW-1];
    logic [NW-1:0]     dv_nq_m  [0:NW];
    logic [DV_TAG-1:0] dv_tag   [0:NW];

    always_comb begin
        dv_valid[0] = r_s6_valid;
        dv_den[0]   = r_s6_den;
        dv_rem_p[0] = '0;
        dv_nq_p[0]  = r_s6_nq_p;
        dv_rem_m[0] = '0;
        dv_nq_m[0]  = r_s6_nq_m;
        dv_tag[0]   = r_s6_tag;
    end

    for (genvar g = 0; g < NW; g++) begin : g_div
        if (g < NW - 1) begin : g_mid
            lci_div_cell #(.DW(W), .NW(NW), .TAG_W(DV_TAG)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (dv_valid[g]),
                .i_den   (dv_den[g]),
                .i_rem_p (dv_rem_p[g]),
                .i_nq_p  (dv_nq_p[g]),
                .i_rem_m (dv_rem_m[g]),
                .i_nq_m  (dv_nq_m[g]),
                .i_tag   (dv_tag[g]),
                .o_valid (dv_valid[g+1]),
                .o_den   (dv_den[g+1]),
                .o_rem_p (dv_rem_p[g+1]),
                .o_nq_p  (dv_nq_p[g+1]),
                .o_rem_m (dv_rem_m[g+1]),
                .o_nq_m  (dv_nq_m[g+1]),
                .o_tag   (dv_tag[g+1])
            );
        end else begin : g_last
            lci_div_cell #(.DW(W), .NW(NW), .TAG_W(DV_TAG)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (dv_valid[g]),
                .i_den   (dv_den[g]),
                .i_rem_p (dv_rem_p[g]),
                .i_nq_p  (dv_nq_p[g]),
                .i_rem_m (dv_rem_m[g]),
                .i_nq_m  (dv_nq_m[g]),
                .i_tag   (dv_tag[g]),
                .o_valid (dv_valid[g+1]),
                .o_den   (dv_den[g+1]),
                .o_rem_p (),
                .o_nq_p  (dv_nq_p[g+1]),
                .o_rem_m (),
                .o_nq_m  (dv_nq_m[g+1]),
                .o_tag   (dv_tag[g+1])
            );
        end
    end

    // Stage 7: signed, saturated quotients. A divisor that is not positive
    // gives zero with the overflow flag. Flags count only for used points.
    logic         r_s7_valid;
    logic [W-1:0] r_s7_fx, r_s7_sx, r_s7_a, r_s7_b;
    t_count       r_s7_cnt;
    logic         r_s7_f;
    t_dv_tag      w_dv_out;
    logic         w_dz;
    logic [W:0]   n_s7_fx, n_s7_sx;

    always_comb begin
        w_dv_out = t_dv_tag'(dv_tag[NW]);
        w_dz     = dv_den[NW][W-1] || (dv_den[NW] == '0);
        n_s7_fx  = w_dz ? {1'b1, {W{1'b0}}} : from_mag(w_dv_out.neg_p, MW'(dv_nq_p[NW]));
        n_s7_sx  = w_dz ? {1'b1, {W{1'b0}}} : from_mag(w_dv_out.neg_m, MW'(dv_nq_m[NW]));
    end

    // Stage 8: slope products for the y coordinates.
    logic         r_s8_valid;
    logic [W-1:0] r_s8_fx, r_s8_sx, r_s8_pf, r_s8_ps, r_s8_b;
    t_count       r_s8_cnt;
    logic         r_s8_f;
    logic [W:0]   n_s8_pf, n_s8_ps;

    always_comb begin
        n_s8_pf = qmul(r_s7_a, r_s7_fx);
        n_s8_ps = qmul(r_s7_a, r_s7_sx);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s7_fx  <= n_s7_fx[W-1:0];
            r_s7_sx  <= n_s7_sx[W-1:0];
            r_s7_a   <= w_dv_out.a;
            r_s7_b   <= w_dv_out.b;
            r_s7_cnt <= w_dv_out.cnt;
            r_s7_f   <= w_dv_out.f
                      | (n_s7_fx[W] && (w_dv_out.cnt != CNT_NONE))
                      | (n_s7_sx[W] && (w_dv_out.cnt == CNT_TWO));

            r_s8_fx  <= r_s7_fx;
            r_s8_sx  <= r_s7_sx;
            r_s8_pf  <= n_s8_pf[W-1:0];
            r_s8_ps  <= n_s8_ps[W-1:0];
            r_s8_b   <= r_s7_b;
            r_s8_cnt <= r_s7_cnt;
            r_s8_f   <= r_s7_f
                      | (n_s8_pf[W] && (r_s7_cnt != CNT_NONE))
                      | (n_s8_ps[W] && (r_s7_cnt == CNT_TWO));
        end
    end

    // Output register: add the intercept and zero the unused points.
    logic         r_out_valid;
    logic [W-1:0] r_out_fx, r_out_fy, r_out_sx, r_out_sy;
    t_count       r_out_cnt;
    logic         r_out_of;
    logic [W:0]   n_out_fy, n_out_sy;

    always_comb begin
        n_out_fy = clamp_w(ext(r_s8_pf) + ext(r_s8_b));
        n_out_sy = clamp_w(ext(r_s8_ps) + ext(r_s8_b));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_fx  <= (r_s8_cnt == CNT_NONE) ? '0 : r_s8_fx;
            r_out_fy  <= (r_s8_cnt == CNT_NONE) ? '0 : n_out_fy[W-1:0];
            r_out_sx  <= (r_s8_cnt == CNT_TWO) ? r_s8_sx : '0;
            r_out_sy  <= (r_s8_cnt == CNT_TWO) ? n_out_sy[W-1:0] : '0;
            r_out_cnt <= r_s8_cnt;
            r_out_of  <= r_s8_f
                       | (n_out_fy[W] && (r_s8_cnt != CNT_NONE))
                       | (n_out_sy[W] && (r_s8_cnt == CNT_TWO));
        end
    end

    // Valid bits of the stages outside the cell chains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_s6_valid  <= 1'b0;
            r_s7_valid  <= 1'b0;
            r_s8_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid  <= i_s_axis_tvalid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_s5_valid  <= r_s4_valid;
            r_s6_valid  <= sq_valid[RW];
            r_s7_valid  <= dv_valid[NW];
            r_s8_valid  <= r_s7_valid;
            r_out_valid <= r_s8_valid;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_sy, r_out_sx, r_out_fy, r_out_fx});
    assign o_m_axis_tuser  = {r_out_of, r_out_cnt};

endmodule

`default_nettype wire

>>> rtl/core/lci_chk.sv
`default_nettype none

module lci_chk
    import lci_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_s_axis_tready,
    input wire logic                               o_m_axis_tvalid,
    input wire logic                               i_m_axis_tready,
    input wire logic [((4*WORD_BITS+7)/8)*8-1:0]   o_m_axis_tdata,
    input wire logic [2:0]                         o_m_axis_tuser
);

    // A word that is not taken stays on the output unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output word changed while stalled");

    // The input side stalls exactly when a held output word blocks the pipeline.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input accepted while pipeline stalled");

    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input refused with empty output");

    // Points that are not reported read zero.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[1:0] == CNT_NONE) |->
            (o_m_axis_tdata[4*WORD_BITS-1:0] == '0))
        else $error("points present with no intersection");

    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[1:0] != CNT_TWO) |->
            (o_m_axis_tdata[4*WORD_BITS-1:2*WORD_BITS] == '0))
        else $error("second point present without two intersections");

endmodule

bind line_circle_intersection lci_chk #(.WORD_BITS(WORD_BITS)) u_lci_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
